### rtl/text_console_scroll_buffer_unit_assert.svh
// Assertion macros shared by the console checker.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef TEXT_CONSOLE_SCROLL_BUFFER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_SCROLL_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCSB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("console assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("console assertion failed");

`endif

### rtl/tcsb_pkg.sv
// Package for the text console scroll buffer: field widths, codes and the
// command and status structs between controller and datapath. No dependencies.
package tcsb_pkg;

    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic settle;
        logic scrl_step;
        logic calc_addr;
        logic exec;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic need_scroll;
        logic scrl_done;
        logic out_free;
    } t_stat;

endpackage

### rtl/tcsb_ifs.sv
// Valid/ready channel interfaces for console items and results.
// Depends on tcsb_pkg for the field widths.
interface tcsb_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [tcsb_pkg::CHAR_W-1:0]  char_code;
    logic [tcsb_pkg::ROW_W-1:0]   read_row;
    logic [tcsb_pkg::COL_W-1:0]   read_col;

    modport source (output valid, op, char_code, read_row, read_col, input ready);
    modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

interface tcsb_out_if;
    logic                         valid;
    logic                         ready;
    logic                         draw_valid;
    logic [tcsb_pkg::CHAR_W-1:0]  draw_char;
    logic [tcsb_pkg::COL_W-1:0]   draw_col;
    logic [tcsb_pkg::ROW_W-1:0]   draw_row;
    logic                         scrolled;
    logic [tcsb_pkg::CHAR_W-1:0]  read_data;

    modport source (output valid, draw_valid, draw_char, draw_col, draw_row, scrolled,
                    read_data, input ready);
    modport sink   (input valid, draw_valid, draw_char, draw_col, draw_row, scrolled,
                    read_data, output ready);
endinterface

### rtl/tcsb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tcsb_ctrl.sv
// Sequencing state machine of the console: clearing pass, item intake,
// cursor settle, scroll row blanking, cell access and result hand-off. Uses tcsb_pkg.
module tcsb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output tcsb_pkg::t_cmd  o_cmd,
    input  tcsb_pkg::t_stat i_stat
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SETTLE = 3'd2;
    localparam logic [2:0] S_SCRL   = 3'd3;
    localparam logic [2:0] S_ADDR   = 3'd4;
    localparam logic [2:0] S_EXEC   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_SETTLE;
                end
            end
            S_SETTLE: begin
                o_cmd.settle = 1'b1;
                n_state      = i_stat.need_scroll ? S_SCRL : S_ADDR;
            end
            S_SCRL: begin
                o_cmd.scrl_step = 1'b1;
                if (i_stat.scrl_done) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.calc_addr = 1'b1;
                n_state         = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### rtl/tcsb_dpath.sv
// Datapath of the console: cursor, ring-buffer row base, address unit,
// cell store RAM and output register. Uses tcsb_pkg and tcsb_ram.
module tcsb_dpath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcsb_pkg::t_cmd                i_cmd,
    output tcsb_pkg::t_stat               o_stat,
    input  logic                          i_op,
    input  logic [tcsb_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcsb_pkg::ROW_W-1:0]    i_read_row,
    input  logic [tcsb_pkg::COL_W-1:0]    i_read_col,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_draw_valid,
    output logic [tcsb_pkg::CHAR_W-1:0]   o_draw_char,
    output logic [tcsb_pkg::COL_W-1:0]    o_draw_col,
    output logic [tcsb_pkg::ROW_W-1:0]    o_draw_row,
    output logic                          o_scrolled,
    output logic [tcsb_pkg::CHAR_W-1:0]   o_read_data
);

    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int AW     = $clog2(DEPTH);
    localparam int COL_CW = $clog2(COLUMNS + 1);
    localparam int ROW_CW = $clog2(ROWS + 1);
    localparam int COL_IW = $clog2(COLUMNS);

    // Item registers.
    logic                        r_op;
    logic [tcsb_pkg::CHAR_W-1:0] r_char;
    logic [tcsb_pkg::ROW_W-1:0]  r_rrow;
    logic [tcsb_pkg::COL_W-1:0]  r_rcol;

    // Cursor and the physical address of logical row 0.
    logic [COL_CW-1:0] r_cur_col;
    logic [ROW_CW-1:0] r_cur_row;
    logic [AW-1:0]     r_base_addr;

    // Clearing pass and scroll blanking.
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_clr_row_addr;
    logic [COL_IW-1:0] r_scol;

    // Access and result registers.
    logic [AW-1:0]               r_addr;
    logic                        r_oob;
    logic                        r_scr;
    logic                        r_dv;
    logic [tcsb_pkg::CHAR_W-1:0] r_dch;
    logic [tcsb_pkg::COL_W-1:0]  r_dcol;
    logic [tcsb_pkg::ROW_W-1:0]  r_drow;

    // Output register.
    logic                        r_out_valid;
    logic                        r_out_dv;
    logic [tcsb_pkg::CHAR_W-1:0] r_out_dch;
    logic [tcsb_pkg::COL_W-1:0]  r_out_dcol;
    logic [tcsb_pkg::ROW_W-1:0]  r_out_drow;
    logic                        r_out_scr;
    logic [tcsb_pkg::CHAR_W-1:0] r_out_rdata;

    logic                        is_write;
    logic                        is_newline;
    logic                        wrap;
    logic [COL_CW-1:0]           col_s;
    logic [ROW_CW-1:0]           row_s;
    logic                        scroll;
    logic [AW-1:0]               base_next;
    logic [AW-1:0]               row_sel;
    logic [AW-1:0]               col_sel;
    logic [AW-1:0]               lin;
    logic [AW:0]                 sum;
    logic [AW-1:0]               phys;
    logic                        oob;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tcsb_pkg::CHAR_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [tcsb_pkg::CHAR_W-1:0] ram_rdata;

    assign is_write   = (r_op == tcsb_pkg::OP_WRITE);
    assign is_newline = (r_char == tcsb_pkg::NEWLINE_CODE);

    // Cursor settle: wrap past the last column, then scroll below the last row.
    assign wrap      = (r_cur_col >= COL_CW'(COLUMNS));
    assign col_s     = wrap ? '0 : r_cur_col;
    assign row_s     = wrap ? (r_cur_row + ROW_CW'(1)) : r_cur_row;
    assign scroll    = is_write && (row_s >= ROW_CW'(ROWS));
    assign base_next = (r_base_addr == AW'(DEPTH - COLUMNS)) ? '0
                                                             : (r_base_addr + AW'(COLUMNS));

    // Logical cell to physical address, rows rotated by the base.
    assign row_sel = is_write ? AW'(r_cur_row) : AW'(r_rrow);
    assign col_sel = is_write ? AW'(r_cur_col) : AW'(r_rcol);
    assign lin     = AW'(row_sel * AW'(COLUMNS)) + col_sel;
    assign sum     = {1'b0, lin} + {1'b0, r_base_addr};
    assign phys    = (sum >= (AW + 1)'(DEPTH)) ? AW'(sum - (AW + 1)'(DEPTH)) : AW'(sum);
    assign oob     = (int'(r_rrow) >= ROWS) || (int'(r_rcol) >= COLUMNS);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = '0;
        if (i_cmd.clr_step) begin
            ram_we = 1'b1;
        end else if (i_cmd.scrl_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_row_addr + AW'(r_scol);
        end else if (i_cmd.exec && is_write && !is_newline) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = r_char;
        end
    end

    assign ram_re = i_cmd.exec && !is_write;

    tcsb_ram #(
        .WIDTH (tcsb_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.clr_done    = (r_clr_addr == AW'(DEPTH - 1));
    assign o_stat.need_scroll = scroll;
    assign o_stat.scrl_done   = (r_scol == COL_IW'(COLUMNS - 1));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_base_addr <= '0;
            r_clr_addr  <= '0;
            r_scol      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.settle && is_write) begin
                r_cur_col <= col_s;
                r_cur_row <= scroll ? ROW_CW'(ROWS - 1) : row_s;
                if (scroll) begin
                    r_base_addr <= base_next;
                end
            end
            if (i_cmd.scrl_step) begin
                r_scol <= o_stat.scrl_done ? '0 : (r_scol + COL_IW'(1));
            end
            if (i_cmd.exec && is_write) begin
                if (is_newline) begin
                    r_cur_col <= '0;
                    r_cur_row <= r_cur_row + ROW_CW'(1);
                end else begin
                    r_cur_col <= r_cur_col + COL_CW'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_char <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
            r_scr  <= 1'b0;
            r_dv   <= 1'b0;
            r_dch  <= '0;
            r_dcol <= '0;
            r_drow <= '0;
        end
        if (i_cmd.settle && is_write) begin
            r_scr          <= scroll;
            // The row that becomes the new bottom row is the old top row.
            r_clr_row_addr <= r_base_addr;
        end
        if (i_cmd.calc_addr) begin
            r_addr <= phys;
            r_oob  <= oob;
        end
        if (i_cmd.exec && is_write && !is_newline) begin
            r_dv   <= 1'b1;
            r_dch  <= r_char;
            r_dcol <= tcsb_pkg::COL_W'(r_cur_col);
            r_drow <= tcsb_pkg::ROW_W'(r_cur_row);
        end
        if (i_cmd.load_out) begin
            r_out_dv    <= r_dv;
            r_out_dch   <= r_dch;
            r_out_dcol  <= r_dcol;
            r_out_drow  <= r_drow;
            r_out_scr   <= r_scr;
            r_out_rdata <= (!is_write && !r_oob) ? ram_rdata : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_draw_valid = r_out_dv;
    assign o_draw_char  = r_out_dch;
    assign o_draw_col   = r_out_dcol;
    assign o_draw_row   = r_out_drow;
    assign o_scrolled   = r_out_scr;
    assign o_read_data  = r_out_rdata;

endmodule

### rtl/text_console_scroll_buffer_unit.sv
// Text console scroll buffer. Items arrive on the i_in channel and carry either a
// character write (op 0) or a read of one stored cell (op 1). Every item gives exactly
// one result item on the o_out channel: a draw report with its cell, a scrolled flag
// and, for reads, the cell contents (0 for a cell outside the screen).
// The cell store is one RAM used as a ring of rows: a scroll moves the row base by one
// row and blanks the new bottom row, one cell per cycle. Items are taken one at a time:
// after an item is accepted, the sequencer steps through settle, scroll blanking for an
// item that scrolls, address, RAM access and hand-off, and only then takes the next item.
// Reset (synchronous, active low) homes the cursor and starts a clearing pass that
// writes zero to all ROWS*COLUMNS cells, one per cycle; i_in.ready stays low until it
// finishes. The result sits in an output register: while the receiver stalls, the
// block still accepts the next item and works on it, then waits with its result
// until the register frees up. Depends on tcsb_pkg, tcsb_ifs, tcsb_ctrl and tcsb_dpath.
module text_console_scroll_buffer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcsb_in_if.sink    i_in,
    tcsb_out_if.source o_out
);

    tcsb_pkg::t_cmd  cmd;
    tcsb_pkg::t_stat stat;
    logic            in_ready;

    // Sequencer: owns the handshake on the input side.
    tcsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    assign i_in.ready = in_ready;

    // Datapath: cursor, cell store and the output register.
    tcsb_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_in.op),
        .i_char_code  (i_in.char_code),
        .i_read_row   (i_in.read_row),
        .i_read_col   (i_in.read_col),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_draw_valid (o_out.draw_valid),
        .o_draw_char  (o_out.draw_char),
        .o_draw_col   (o_out.draw_col),
        .o_draw_row   (o_out.draw_row),
        .o_scrolled   (o_out.scrolled),
        .o_read_data  (o_out.read_data)
    );

endmodule

### rtl/tcsb_checker.sv
// Port-level checker for the console, bound to the top level.
// Depends on tcsb_pkg and text_console_scroll_buffer_unit_assert.svh.
`include "text_console_scroll_buffer_unit_assert.svh"

module tcsb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_draw_valid,
    input logic [tcsb_pkg::CHAR_W-1:0] i_draw_char,
    input logic [tcsb_pkg::COL_W-1:0]  i_draw_col,
    input logic [tcsb_pkg::ROW_W-1:0]  i_draw_row,
    input logic                        i_scrolled,
    input logic [tcsb_pkg::CHAR_W-1:0] i_read_data
);

    // The block works on one item at a time.
    `TCSB_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A draw comes from a write, so it never carries read data.
    `TCSB_ASSERT_IMPL(a_draw_no_read_data, i_clk, i_rst_n, i_out_valid && i_draw_valid, i_read_data == '0)

    // Without a draw the draw fields are zero.
    `TCSB_ASSERT_IMPL(a_no_draw_fields_zero, i_clk, i_rst_n, i_out_valid && !i_draw_valid, (i_draw_char == '0) && (i_draw_col == '0) && (i_draw_row == '0))

    // A stalled result holds.
    `TCSB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_draw_valid) && $stable(i_draw_char) && $stable(i_draw_col) && $stable(i_draw_row) && $stable(i_scrolled) && $stable(i_read_data))

endmodule

bind text_console_scroll_buffer_unit tcsb_checker u_tcsb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_draw_valid (o_out.draw_valid),
    .i_draw_char  (o_out.draw_char),
    .i_draw_col   (o_out.draw_col),
    .i_draw_row   (o_out.draw_row),
    .i_scrolled   (o_out.scrolled),
    .i_read_data  (o_out.read_data)
);

### tb/text_console_scroll_buffer_unit_tb.sv
// Self-checking testbench for the text console scroll buffer: a directed table, then
// random text, newline bursts, cell reads and noise, all checked by a console predictor.
// Depends on tcsb_pkg, tcsb_ifs and the text_console_scroll_buffer_unit RTL.
module text_console_scroll_buffer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_COLS   = 80;
    localparam int SCREEN_ROWS   = 25;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1350;
    // After the last expected result, a scroll and the hand-off can still be in flight.
    localparam int SETTLE_CYCLES = 2 * SCREEN_COLS + 20;
    // The limit leaves a wide margin above the slowest correct run (clearing pass,
    // scrolls, full gaps and stalls, the long hold-offs).
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;
    localparam int DIRECTED_ROWS = 22;

    localparam logic OP_RD = tcsb_pkg::OP_READ;
    localparam logic OP_WR = tcsb_pkg::OP_WRITE;

    // One input item and one result item, at the block's field widths.
    typedef struct packed {
        logic                        op;
        logic [tcsb_pkg::CHAR_W-1:0] char_code;
        logic [tcsb_pkg::ROW_W-1:0]  read_row;
        logic [tcsb_pkg::COL_W-1:0]  read_col;
    } t_console_item;

    typedef struct packed {
        logic                        draw_valid;
        logic [tcsb_pkg::CHAR_W-1:0] draw_char;
        logic [tcsb_pkg::COL_W-1:0]  draw_col;
        logic [tcsb_pkg::ROW_W-1:0]  draw_row;
        logic                        scrolled;
        logic [tcsb_pkg::CHAR_W-1:0] read_data;
    } t_console_result;

    // A directed row: the item, and a typed-in result where it is obvious by eye.
    // Rows with known_result low are checked against the predictor instead.
    typedef struct packed {
        t_console_item   item;
        logic            known_result;
        t_console_result result;
    } t_console_case;

    localparam t_console_result QUIET = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcsb_in_if  in_ch ();
    tcsb_out_if out_ch ();

    text_console_scroll_buffer_unit #(
        .COLUMNS(SCREEN_COLS),
        .ROWS   (SCREEN_ROWS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow copy of the screen and the cursor. The cursor may sit one past the last
    // column or the last row; the wrap and the scroll are settled at the next write.
    logic [tcsb_pkg::CHAR_W-1:0] shadow_cells [SCREEN_ROWS][SCREEN_COLS];
    int                          pen_col;
    int                          pen_row;

    t_console_result pending_results [$];
    int              mismatch_count = 0;
    int              items_offered  = 0;
    bit              sender_eager   = 1'b0;
    bit              drain_eager    = 1'b0;

    // Directed items. The first reads prove the clearing pass, including cells just off
    // the screen; then draws at the top-left corner with the extreme byte values, a read
    // that carries the newline code (it must not move the cursor), two newlines, and a
    // few rows left to the predictor.
    t_console_case directed_cases [DIRECTED_ROWS] = '{
        '{'{OP_RD, 8'h00, 5'd0,  7'd0},   1'b1, QUIET},
        '{'{OP_RD, 8'h00, 5'd24, 7'd79},  1'b1, QUIET},
        '{'{OP_RD, 8'hFF, 5'd31, 7'd127}, 1'b1, QUIET},
        '{'{OP_RD, 8'h00, 5'd25, 7'd0},   1'b1, QUIET},
        '{'{OP_RD, 8'h00, 5'd0,  7'd80},  1'b1, QUIET},
        '{'{OP_WR, 8'h41, 5'd0,  7'd0},   1'b1, '{1'b1, 8'h41, 7'd0, 5'd0, 1'b0, 8'h00}},
        '{'{OP_WR, 8'hFF, 5'd31, 7'd127}, 1'b1, '{1'b1, 8'hFF, 7'd1, 5'd0, 1'b0, 8'h00}},
        '{'{OP_WR, 8'h00, 5'd0,  7'd0},   1'b1, '{1'b1, 8'h00, 7'd2, 5'd0, 1'b0, 8'h00}},
        '{'{OP_WR, 8'h80, 5'd10, 7'd64},  1'b1, '{1'b1, 8'h80, 7'd3, 5'd0, 1'b0, 8'h00}},
        '{'{OP_RD, 8'hFF, 5'd0,  7'd1},   1'b1, '{1'b0, 8'h00, 7'd0, 5'd0, 1'b0, 8'hFF}},
        '{'{OP_RD, 8'h0A, 5'd0,  7'd0},   1'b1, '{1'b0, 8'h00, 7'd0, 5'd0, 1'b0, 8'h41}},
        '{'{OP_WR, 8'h0A, 5'd0,  7'd0},   1'b1, QUIET},
        '{'{OP_WR, 8'h0A, 5'd31, 7'd127}, 1'b1, QUIET},
        '{'{OP_WR, 8'h7F, 5'd0,  7'd0},   1'b1, '{1'b1, 8'h7F, 7'd0, 5'd2, 1'b0, 8'h00}},
        '{'{OP_RD, 8'h00, 5'd2,  7'd0},   1'b1, '{1'b0, 8'h00, 7'd0, 5'd0, 1'b0, 8'h7F}},
        '{'{OP_RD, 8'h55, 5'd0,  7'd3},   1'b0, QUIET},
        '{'{OP_WR, 8'h0B, 5'd21, 7'd42},  1'b0, QUIET},
        '{'{OP_WR, 8'h09, 5'd0,  7'd0},   1'b0, QUIET},
        '{'{OP_WR, 8'h01, 5'd16, 7'd64},  1'b0, QUIET},
        '{'{OP_WR, 8'hFE, 5'd31, 7'd127}, 1'b0, QUIET},
        '{'{OP_RD, 8'hAA, 5'd2,  7'd4},   1'b0, QUIET},
        '{'{OP_RD, 8'h55, 5'd24, 7'd79},  1'b0, QUIET}
    };

    // Works out the result of one item and updates the shadow screen and cursor.
    function automatic t_console_result console_predict(input t_console_item it);
        t_console_result res;
        int r;
        int c;
        res = QUIET;
        if (it.op == OP_RD) begin
            // Reads leave the state alone; a cell off the screen reads as zero.
            if (it.read_row < SCREEN_ROWS && it.read_col < SCREEN_COLS) begin
                res.read_data = shadow_cells[it.read_row][it.read_col];
            end
        end else begin
            if (pen_col >= SCREEN_COLS) begin
                pen_col = 0;
                pen_row++;
            end
            // Past the bottom: move every row up one, blank the last row.
            if (pen_row >= SCREEN_ROWS) begin
                for (r = 0; r < SCREEN_ROWS - 1; r++) begin
                    for (c = 0; c < SCREEN_COLS; c++) begin
                        shadow_cells[r][c] = shadow_cells[r+1][c];
                    end
                end
                for (c = 0; c < SCREEN_COLS; c++) begin
                    shadow_cells[SCREEN_ROWS-1][c] = '0;
                end
                pen_row      = SCREEN_ROWS - 1;
                res.scrolled = 1'b1;
            end
            if (it.char_code == tcsb_pkg::NEWLINE_CODE) begin
                pen_col = 0;
                pen_row++;
            end else begin
                shadow_cells[pen_row][pen_col] = it.char_code;
                res.draw_valid = 1'b1;
                res.draw_char  = it.char_code;
                res.draw_col   = tcsb_pkg::COL_W'(pen_col);
                res.draw_row   = tcsb_pkg::ROW_W'(pen_row);
                pen_col++;
            end
        end
        return res;
    endfunction

    // A write with random bytes in the unused read fields.
    function automatic t_console_item write_item(input logic [tcsb_pkg::CHAR_W-1:0] glyph);
        t_console_item it;
        it.op        = OP_WR;
        it.char_code = glyph;
        it.read_row  = tcsb_pkg::ROW_W'($urandom_range(0, 31));
        it.read_col  = tcsb_pkg::COL_W'($urandom_range(0, 127));
        return it;
    endfunction

    // A cell read with a random byte in the unused character field.
    function automatic t_console_item read_item(input int row, input int col);
        t_console_item it;
        it.op        = OP_RD;
        it.char_code = tcsb_pkg::CHAR_W'($urandom_range(0, 255));
        it.read_row  = tcsb_pkg::ROW_W'(row);
        it.read_col  = tcsb_pkg::COL_W'(col);
        return it;
    endfunction

    // Offers one item after a random gap and waits for it to be taken. Valid stays high
    // across back-to-back items so that it is never dropped and raised in one step.
    task automatic offer_item(input t_console_item it, input logic known,
                              input t_console_result typed);
        int gap;
        t_console_result predicted;
        gap = sender_eager ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= it.op;
        in_ch.char_code <= it.char_code;
        in_ch.read_row  <= it.read_row;
        in_ch.read_col  <= it.read_col;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        // The predictor runs on every accepted item so the shadow state stays in step,
        // even where the directed table supplies the result by hand.
        predicted = console_predict(it);
        pending_results.push_back(known ? typed : predicted);
        items_offered++;
    endtask

    task automatic compare_field(input string name,
                                 input logic [tcsb_pkg::CHAR_W-1:0] want,
                                 input logic [tcsb_pkg::CHAR_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result checker: every accepted result item is matched against the oldest
    // expectation. Signals are read right after the edge, so they hold the values that
    // the edge itself sampled.
    always @(posedge i_clk) begin : result_check
        t_console_result got;
        t_console_result want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.draw_valid = out_ch.draw_valid;
            got.draw_char  = out_ch.draw_char;
            got.draw_col   = out_ch.draw_col;
            got.draw_row   = out_ch.draw_row;
            got.scrolled   = out_ch.scrolled;
            got.read_data  = out_ch.read_data;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: expected no result item, actual %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                compare_field("draw_valid", tcsb_pkg::CHAR_W'(want.draw_valid),
                              tcsb_pkg::CHAR_W'(got.draw_valid));
                compare_field("draw_char", want.draw_char, got.draw_char);
                compare_field("draw_col", tcsb_pkg::CHAR_W'(want.draw_col),
                              tcsb_pkg::CHAR_W'(got.draw_col));
                compare_field("draw_row", tcsb_pkg::CHAR_W'(want.draw_row),
                              tcsb_pkg::CHAR_W'(got.draw_row));
                compare_field("scrolled", tcsb_pkg::CHAR_W'(want.scrolled),
                              tcsb_pkg::CHAR_W'(got.scrolled));
                compare_field("read_data", want.read_data, got.read_data);
            end
        end
    end

    // Result receiver. It may stall before each item, with runs of no stalls at all.
    // Twice it holds ready low for a long stretch while the sender keeps offering, so
    // the output register fills, the next item is taken and finished, and then the
    // input side has to stall as well.
    initial begin : result_drain
        int stall;
        int taken;
        taken = 0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = drain_eager ? 0 : $urandom_range(0, 7);
            if (taken == 300 || taken == 800) begin
                stall = 250;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            taken++;
            if ($urandom_range(0, 39) == 0) begin
                drain_eager = ~drain_eager;
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int r;
        int c;
        int k;
        int kind;
        int run_len;
        logic [tcsb_pkg::CHAR_W-1:0] glyph;
        t_console_item noise;

        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= OP_WR;
        in_ch.char_code <= '0;
        in_ch.read_row  <= '0;
        in_ch.read_col  <= '0;
        for (r = 0; r < SCREEN_ROWS; r++) begin
            for (c = 0; c < SCREEN_COLS; c++) begin
                shadow_cells[r][c] = '0;
            end
        end
        pen_col = 0;
        pen_row = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block holds ready low during its clearing pass; the first item just waits.
        for (k = 0; k < DIRECTED_ROWS; k++) begin
            offer_item(directed_cases[k].item, directed_cases[k].known_result,
                       directed_cases[k].result);
        end

        // Random part, built from segments that look like console traffic. Text lines
        // are mostly short, some long enough to wrap past the last column; newline
        // bursts push the cursor off the bottom so that scrolls come both from newlines
        // and from the write after a newline on the last row.
        while (items_offered < DIRECTED_ROWS + RANDOM_ITEMS) begin
            kind         = $urandom_range(0, 9);
            sender_eager = ($urandom_range(0, 4) == 0);
            case (kind)
                0, 1, 2, 3, 4: begin
                    run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 170)
                                                          : $urandom_range(0, 30);
                    repeat (run_len) begin
                        glyph = tcsb_pkg::CHAR_W'($urandom_range(0, 255));
                        if (glyph == tcsb_pkg::NEWLINE_CODE) begin
                            glyph = 8'h20;
                        end
                        offer_item(write_item(glyph), 1'b0, QUIET);
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        offer_item(write_item(tcsb_pkg::NEWLINE_CODE), 1'b0, QUIET);
                    end
                end
                5, 6: begin
                    // Mostly on-screen reads to look at the content; some anywhere in
                    // the field ranges, which covers the cells off the screen.
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 6) == 0) begin
                            offer_item(read_item($urandom_range(0, 31),
                                                 $urandom_range(0, 127)), 1'b0, QUIET);
                        end else begin
                            offer_item(read_item($urandom_range(0, SCREEN_ROWS - 1),
                                                 $urandom_range(0, SCREEN_COLS - 1)),
                                       1'b0, QUIET);
                        end
                    end
                end
                7: begin
                    repeat ($urandom_range(1, 30)) begin
                        offer_item(write_item(tcsb_pkg::NEWLINE_CODE), 1'b0, QUIET);
                    end
                end
                default: begin
                    // Noise: every field fully random, either operation.
                    repeat ($urandom_range(1, 10)) begin
                        noise.op        = 1'($urandom_range(0, 1));
                        noise.char_code = tcsb_pkg::CHAR_W'($urandom_range(0, 255));
                        noise.read_row  = tcsb_pkg::ROW_W'($urandom_range(0, 31));
                        noise.read_col  = tcsb_pkg::COL_W'($urandom_range(0, 127));
                        offer_item(noise, 1'b0, QUIET);
                    end
                end
            endcase
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached, %0d results still expected",
                 $time, pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
